/* rtl/core/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the byte ring buffer: operation and status
// codes, field widths and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package brb_pkg;

  // fixed field widths of the stream words
  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned StatusW = 2;

  // packed stream word widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 64;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_PEEK    = 3'd1,
    OP_DEQUEUE = 3'd2,
    OP_STAGED  = 3'd3,
    OP_COMMIT  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  // one finished result, minus the store read data
  typedef struct packed {
    logic                is_peek;
    logic [CountW-1:0]   done_count;
    logic [CountW-1:0]   fill_level;
    logic [CountW-1:0]   direct_enqueue;
    logic [CountW-1:0]   direct_dequeue;
    status_e             status;
  } result_t;

endpackage

/* rtl/core/brb_ram.sv */
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-port RAM with one write or one read per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/brb_ctrl.sv */
// ----------------------------------------------------------------------------
// brb_ctrl
// Ring state (read index, write index, fill count, capacity) and the single
// pass that executes one operation, drives the store and forms the result.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brb_pkg::CountW-1:0]     cfg_data_i,
  input  logic                           fire_i,
  input  logic [brb_pkg::OpW-1:0]        op_i,
  input  logic [brb_pkg::ByteW-1:0]      data_byte_i,
  input  logic [brb_pkg::OffW-1:0]       offset_i,
  input  logic [brb_pkg::CountW-1:0]     amount_i,
  output logic                           ram_we_o,
  output logic                           ram_re_o,
  output logic [$clog2(DEPTH)-1:0]       ram_addr_o,
  output logic [brb_pkg::ByteW-1:0]      ram_wdata_o,
  output brb_pkg::result_t               result_o
);

  import brb_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CalcW = ((CntW > CountW) ? CntW : CountW) + 1;
  localparam logic [CalcW-1:0] DepthC = CalcW'(DEPTH);

  logic [IdxW-1:0] rd_q, rd_d;
  logic [IdxW-1:0] wr_q, wr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] cap_q, cap_d;

  logic [CalcW-1:0] cap_c, fill_c, free_c, rd_c, wr_c, off_c, amt_c;
  logic [CalcW-1:0] cfg_c;
  logic [CalcW-1:0] wbase, wdist, wsum, wrapped;
  logic [CalcW-1:0] n_deq, n_com, fill_n, rd_n, wr_n, done_n;
  logic [CalcW-1:0] span_enq, span_deq;
  logic             deq_clamp, com_clamp;
  logic             ram_we, ram_re;
  status_e          status;
  op_e              op;

  assign op     = op_e'(op_i);
  assign cap_c  = CalcW'(cap_q);
  assign fill_c = CalcW'(fill_q);
  assign free_c = cap_c - fill_c;
  assign rd_c   = CalcW'(rd_q);
  assign wr_c   = CalcW'(wr_q);
  assign off_c  = CalcW'(offset_i);
  assign amt_c  = CalcW'(amount_i);
  assign cfg_c  = CalcW'(cfg_data_i);

  // clamped counts for dequeue and commit
  assign deq_clamp = amt_c > fill_c;
  assign com_clamp = amt_c > free_c;
  assign n_deq     = deq_clamp ? fill_c : amt_c;
  assign n_com     = com_clamp ? free_c : amt_c;

  // one shared wrap adder: base plus distance folded into the ring
  always_comb begin
    wbase = wr_c;
    wdist = {{(CalcW-1){1'b0}}, 1'b1};
    case (op)
      OP_PEEK:    begin wbase = rd_c; wdist = off_c; end
      OP_DEQUEUE: begin wbase = rd_c; wdist = n_deq; end
      OP_STAGED:  begin wbase = wr_c; wdist = off_c; end
      OP_COMMIT:  begin wbase = wr_c; wdist = n_com; end
      default:    begin wbase = wr_c; wdist = {{(CalcW-1){1'b0}}, 1'b1}; end
    endcase
  end

  assign wsum    = wbase + wdist;
  assign wrapped = (wsum >= cap_c) ? (wsum - cap_c) : wsum;

  // operation decode
  always_comb begin
    rd_n   = rd_c;
    wr_n   = wr_c;
    fill_n = fill_c;
    done_n = '0;
    status = ST_OK;
    ram_we = 1'b0;
    ram_re = 1'b0;
    unique case (op)
      OP_ENQUEUE: begin
        if (free_c == '0) begin
          status = ST_FULL;
        end else begin
          ram_we = 1'b1;
          wr_n   = wrapped;
          fill_n = fill_c + 1'b1;
          done_n = {{(CalcW-1){1'b0}}, 1'b1};
        end
      end
      OP_PEEK: begin
        if (off_c >= fill_c) begin
          status = ST_RANGE;
        end else begin
          ram_re = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        rd_n   = wrapped;
        fill_n = fill_c - n_deq;
        done_n = n_deq;
        if (deq_clamp) begin
          status = ST_CLAMPED;
        end
      end
      OP_STAGED: begin
        if (off_c >= free_c) begin
          status = ST_RANGE;
        end else begin
          ram_we = 1'b1;
        end
      end
      OP_COMMIT: begin
        wr_n   = wrapped;
        fill_n = fill_c + n_com;
        done_n = n_com;
        if (com_clamp) begin
          status = ST_CLAMPED;
        end
      end
      OP_CLEAR: begin
        rd_n   = '0;
        wr_n   = '0;
        fill_n = '0;
      end
      default: begin
      end
    endcase
  end

  // contiguous spans after the operation
  always_comb begin
    if (wr_n > rd_n) begin
      span_enq = cap_c - wr_n;
      span_deq = wr_n - rd_n;
    end else if (wr_n < rd_n) begin
      span_enq = rd_n - wr_n;
      span_deq = cap_c - rd_n;
    end else if (fill_n == '0) begin
      span_enq = cap_c - wr_n;
      span_deq = '0;
    end else begin
      span_enq = '0;
      span_deq = cap_c - rd_n;
    end
  end

  // next state: a capacity write restarts the ring
  always_comb begin
    rd_d   = rd_q;
    wr_d   = wr_q;
    fill_d = fill_q;
    cap_d  = cap_q;
    if (cfg_we_i) begin
      rd_d   = '0;
      wr_d   = '0;
      fill_d = '0;
      if (cfg_c == '0) begin
        cap_d = {{(CntW-1){1'b0}}, 1'b1};
      end else if (cfg_c > DepthC) begin
        cap_d = CntW'(DEPTH);
      end else begin
        cap_d = cfg_c[CntW-1:0];
      end
    end else if (fire_i) begin
      rd_d   = rd_n[IdxW-1:0];
      wr_d   = wr_n[IdxW-1:0];
      fill_d = fill_n[CntW-1:0];
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
      cap_q  <= CntW'(DEPTH);
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      fill_q <= fill_d;
      cap_q  <= cap_d;
    end
  end

  // store access
  assign ram_we_o    = fire_i & ram_we;
  assign ram_re_o    = fire_i & ram_re;
  assign ram_addr_o  = wrapped[IdxW-1:0] & {IdxW{~(op == OP_ENQUEUE)}} |
                       wr_q & {IdxW{op == OP_ENQUEUE}};
  assign ram_wdata_o = data_byte_i;

  // result record; only an in-range peek returns store data
  assign result_o.is_peek        = ram_re;
  assign result_o.done_count     = done_n[CountW-1:0];
  assign result_o.fill_level     = fill_n[CountW-1:0];
  assign result_o.direct_enqueue = span_enq[CountW-1:0];
  assign result_o.direct_dequeue = span_deq[CountW-1:0];
  assign result_o.status         = status;

endmodule

/* rtl/core/brb_out.sv */
// ----------------------------------------------------------------------------
// brb_out
// Two result stages: the first one lines up with the store read data, the
// second one is the output register that holds a word while the sink stalls.
// ----------------------------------------------------------------------------
module brb_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  brb_pkg::result_t                 result_i,
  input  logic [brb_pkg::ByteW-1:0]        rdata_i,
  output logic                             ready_o,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [brb_pkg::ByteW-1:0]        read_byte_o,
  output brb_pkg::result_t                 result_o
);

  import brb_pkg::*;

  logic             a_valid_q, a_valid_d;
  result_t          a_res_q;
  logic             b_valid_q, b_valid_d;
  result_t          b_res_q;
  logic [ByteW-1:0] b_byte_q;
  logic             a_move;

  // the first stage moves on when the output register is free or taken
  assign a_move  = a_valid_q & (~b_valid_q | m_ready_i);
  assign ready_o = ~a_valid_q | a_move;

  // valid flags
  always_comb begin
    a_valid_d = a_valid_q;
    if (fire_i) begin
      a_valid_d = 1'b1;
    end else if (a_move) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    if (a_move) begin
      b_valid_d = 1'b1;
    end else if (m_ready_i) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      a_res_q <= result_i;
    end
    if (a_move) begin
      b_res_q  <= a_res_q;
      b_byte_q <= a_res_q.is_peek ? rdata_i : '0;
    end
  end

  assign m_valid_o   = b_valid_q;
  assign read_byte_o = b_byte_q;
  assign result_o    = b_res_q;

endmodule

/* rtl/core/byte_ring_buffer.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO over a fixed store with enqueue, peek, dequeue, staged
// write, commit and clear; every operation returns one result word.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | operation word
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | result word
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | capacity_in_use
//
//  one operation word is taken every cycle while s_axis_tready is high; its
//  result goes through the first result stage, lined up with the store read
//  data, then the output register. reset clears the indices and fill count
//  and sets the capacity to DEPTH; the store itself is not cleared.
//  a stalled sink is absorbed by two result stages before s_axis_tready drops.
//  a capacity write restarts the ring with empty indices.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [brb_pkg::CountW-1:0]    cfg_data_i,
  // operation words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte[7:0], offset[19:8], amount[32:20], zero pad[39:33]
  input  logic [brb_pkg::InDataW-1:0]   s_axis_tdata,
  // op[2:0]
  input  logic [brb_pkg::OpW-1:0]       s_axis_tuser,
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_byte[7:0], done_count[20:8], fill_level[33:21],
  // direct_enqueue[46:34], direct_dequeue[59:47], zero pad[63:60]
  output logic [brb_pkg::OutDataW-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [brb_pkg::StatusW-1:0]   m_axis_tuser
);

  import brb_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic             fire;
  logic             in_ready;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_addr;
  logic [ByteW-1:0] ram_wdata, ram_rdata;
  logic [ByteW-1:0] read_byte;
  result_t          result_c, result_out;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;
  assign fire          = s_axis_tvalid & in_ready;

  // ring state and operation pass
  brb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .op_i        (s_axis_tuser),
    .data_byte_i (s_axis_tdata[7:0]),
    .offset_i    (s_axis_tdata[19:8]),
    .amount_i    (s_axis_tdata[32:20]),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .result_o    (result_c)
  );

  // byte store
  brb_ram #(
    .WIDTH (ByteW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result stages
  brb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (result_c),
    .rdata_i     (ram_rdata),
    .ready_o     (in_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .read_byte_o (read_byte),
    .result_o    (result_out)
  );

  // result word packing
  assign m_axis_tdata = {4'b0000,
                         result_out.direct_dequeue,
                         result_out.direct_enqueue,
                         result_out.fill_level,
                         result_out.done_count,
                         read_byte};
  assign m_axis_tuser = result_out.status;

endmodule
